>>> rtl/core/lpht_pkg.sv
// Package for the linear probe hash table: sizes, codes and word types.
// Depends on nothing; every module of the block imports it.
`default_nettype none
package lpht_pkg;
  localparam int unsigned Slots = 256;
  localparam int unsigned IdxW = $clog2(Slots);
  localparam int unsigned CntW = IdxW + 1;
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW = $clog2(QDepth);

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_REM = 2'd2,
    CMD_BAD = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_LIVE  = 2'd1,
    MARK_TOMB  = 2'd2,
    MARK_NONE  = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_MISS     = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  key_type;
    logic [63:0] key_value;
    logic [31:0] key_hash;
    logic [63:0] data_in;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] data_out;
    logic [2:0]  status;
  } rsp_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic            probe;    // needs a table walk
    logic [1:0]      cmd;
    logic [2:0]      key_type;
    logic [63:0]     key_value;
    logic [IdxW-1:0] home;
    logic [63:0]     data_in;
  } job_t;
endpackage
`default_nettype wire

>>> rtl/core/lpht_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on lpht_pkg.
`default_nettype none
module lpht_front import lpht_pkg::*; (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic start_i,
  input  wire  req_t req_i,
  output logic       busy_o,
  output logic       job_valid_o,
  output job_t       job_o,
  input  wire  logic job_pop_i
);
  job_t             q_mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QPtrW:0]   cnt_q, cnt_d;
  logic             push;
  job_t             job_new;

  // The queue is full when it holds QDepth words.
  assign busy_o = (cnt_q == (QPtrW+1)'(QDepth));
  assign push   = start_i && !busy_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o  = q_mem[rd_q];

  // Classify: an unknown command needs no table walk.
  always_comb begin
    job_new.probe     = (req_i.cmd != CMD_BAD);
    job_new.cmd       = req_i.cmd;
    job_new.key_type  = req_i.key_type;
    job_new.key_value = req_i.key_value;
    job_new.home      = req_i.key_hash[IdxW-1:0];
    job_new.data_in   = req_i.data_in;
  end

  // Pointer and count update.
  always_comb begin
    wr_d  = push ? QPtrW'(wr_q + 1'b1) : wr_q;
    rd_d  = job_pop_i ? QPtrW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + (QPtrW+1)'(push) - (QPtrW+1)'(job_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= job_new;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/lpht_back.sv
// Back end: walks the table slot by slot, reading then checking each, and carries out each request.
// Depends on lpht_pkg.
`default_nettype none
module lpht_back import lpht_pkg::*; (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic [8:0] limit_i,
  input  wire  logic       job_valid_i,
  input  wire  job_t       job_i,
  output logic             job_pop_o,
  output logic             idle_o,
  output logic             done_o,
  output rsp_t             rsp_o
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_CHECK = 5'b00100,
    S_WRITE = 5'b01000,
    S_CLEAR = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Slot memories; marks are cleared by a sweep after reset.
  logic [1:0]  mark_mem [Slots];
  logic [2:0]  type_mem [Slots];
  logic [63:0] key_mem  [Slots];
  logic [63:0] data_mem [Slots];

  logic [1:0]  rd_mark_q;
  logic [2:0]  rd_type_q;
  logic [63:0] rd_key_q, rd_data_q;

  job_t            job_q;
  logic [IdxW-1:0] idx_q, idx_d, tomb_q, tomb_d;
  logic [CntW-1:0] steps_q, steps_d;
  logic            have_tomb_q, have_tomb_d;
  logic [CntW-1:0] live_q, live_d, used_q, used_d;
  logic            done_d;
  rsp_t            rsp_d;

  // Write port.
  logic            we_mark, we_entry, we_data;
  logic [IdxW-1:0] wa;
  logic [1:0]      wmark;

  logic            matched;
  logic [CntW:0]   new_used;
  logic [IdxW-1:0] free_slot;
  logic            free_empty;

  assign idle_o = (state_q == S_IDLE);
  assign matched = (rd_mark_q == MARK_LIVE) && (rd_type_q == job_q.key_type)
                   && (rd_key_q == job_q.key_value);

  // Probe sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    tomb_d      = tomb_q;
    have_tomb_d = have_tomb_q;
    steps_d     = steps_q;
    live_d      = live_q;
    used_d      = used_q;
    done_d      = 1'b0;
    rsp_d       = '{hit: 1'b0, data_out: '0, status: ST_MISS};
    job_pop_o   = 1'b0;
    we_mark     = 1'b0;
    we_entry    = 1'b0;
    we_data     = 1'b0;
    wa          = idx_q;
    wmark       = MARK_LIVE;
    free_slot   = idx_q;
    free_empty  = 1'b0;
    new_used    = '0;
    unique case (state_q)
      S_CLEAR: begin
        we_mark = 1'b1;
        wmark   = MARK_EMPTY;
        idx_d   = IdxW'(idx_q + 1'b1);
        if (idx_q == IdxW'(Slots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (job_valid_i) begin
          job_pop_o   = 1'b1;
          idx_d       = job_i.home;
          have_tomb_d = 1'b0;
          steps_d     = '0;
          if (!job_i.probe || (job_i.cmd == CMD_GET && live_q == '0)) begin
            done_d = 1'b1;
          end else begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (matched) begin
          done_d     = 1'b1;
          rsp_d.hit  = 1'b1;
          state_d    = S_IDLE;
          unique case (job_q.cmd)
            CMD_GET: begin
              rsp_d.data_out = rd_data_q;
              rsp_d.status   = ST_FOUND;
            end
            CMD_SET: begin
              rsp_d.status = ST_FOUND;
              we_data      = 1'b1;
            end
            default: begin
              rsp_d.status = ST_REMOVED;
              we_mark      = 1'b1;
              wmark        = MARK_TOMB;
              if (live_q != '0) begin
                live_d = live_q - 1'b1;
              end
            end
          endcase
        end else if (rd_mark_q == MARK_EMPTY ||
                     steps_q == CntW'(Slots - 1)) begin
          // End of the walk: empty slot, or the whole table visited.
          if (rd_mark_q == MARK_TOMB && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = idx_q;
          end
          state_d = S_IDLE;
          done_d  = 1'b1;
          if (job_q.cmd == CMD_SET) begin
            if (have_tomb_d) begin
              free_slot  = tomb_d;
            end else begin
              free_slot  = idx_q;
              free_empty = (rd_mark_q == MARK_EMPTY);
            end
            new_used = {1'b0, used_q} + (CntW+1)'(free_empty);
            if (!have_tomb_d && !free_empty) begin
              rsp_d.status = ST_FULL;
            end else if (new_used >= (CntW+1)'(limit_i)) begin
              rsp_d.status = ST_FULL;
            end else begin
              rsp_d.status = ST_INSERTED;
              used_d   = new_used[CntW-1:0];
              live_d   = live_q + 1'b1;
              we_mark  = 1'b1;
              we_entry = 1'b1;
              we_data  = 1'b1;
              wa       = free_slot;
              wmark    = MARK_LIVE;
            end
          end
        end else begin
          if (rd_mark_q == MARK_TOMB && !have_tomb_q) begin
            have_tomb_d = 1'b1;
            tomb_d      = idx_q;
          end
          idx_d   = IdxW'(idx_q + 1'b1);
          steps_d = steps_q + 1'b1;
          state_d = S_READ;
        end
        if (matched) begin
          wa = idx_q;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      tomb_q      <= '0;
      have_tomb_q <= 1'b0;
      steps_q     <= '0;
      live_q      <= '0;
      used_q      <= '0;
      done_o      <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      tomb_q      <= tomb_d;
      have_tomb_q <= have_tomb_d;
      steps_q     <= steps_d;
      live_q      <= live_d;
      used_q      <= used_d;
      done_o      <= done_d;
    end
  end

  // Result word and captured request.
  always_ff @(posedge clk_i) begin
    rsp_o <= rsp_d;
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  // Memories: registered reads, one write port.
  always_ff @(posedge clk_i) begin
    rd_mark_q <= mark_mem[idx_q];
    rd_type_q <= type_mem[idx_q];
    rd_key_q  <= key_mem[idx_q];
    rd_data_q <= data_mem[idx_q];
    if (we_mark) begin
      mark_mem[wa] <= wmark;
    end
    if (we_entry) begin
      type_mem[wa] <= job_q.key_type;
      key_mem[wa]  <= job_q.key_value;
    end
    if (we_data) begin
      data_mem[wa] <= job_q.data_in;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/linear_probe_hash_table_unit.sv
// Top level of the linear probe hash table: limit register, front and back ends.
// Depends on lpht_pkg, lpht_front and lpht_back.
`default_nettype none
// A request walks its probed slots in turn (registered read, then check),
// between the queue and the registered result.
// A get on an empty table and an unknown command answer without a probe walk.
// The probe walk through the slot memory sets how long a request takes.
// After reset the block clears the slot marks, with busy high once
// the queue fills; the limit register should be written only while no
// request is in flight.
// Each result is on rsp_o for one cycle with done_o high and is not held.
module linear_probe_hash_table_unit import lpht_pkg::*; (
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       start,
  output logic             busy,
  input  wire  req_t       req_i,
  output logic             done_o,
  output rsp_t             rsp_o,
  input  wire  logic       cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  logic [8:0] cfg_data_i
);
  logic [8:0] limit_q;
  logic       job_valid, job_pop, back_idle;
  job_t       job;

  assign cfg_ready_o = 1'b1;

  // Used-slot limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 9'd192;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  lpht_front u_front (
    .clk_i, .rst_ni, .start_i(start), .req_i, .busy_o(busy),
    .job_valid_o(job_valid), .job_o(job), .job_pop_i(job_pop)
  );

  lpht_back u_back (
    .clk_i, .rst_ni, .limit_i(limit_q), .job_valid_i(job_valid), .job_i(job),
    .job_pop_o(job_pop), .idle_o(back_idle), .done_o, .rsp_o
  );

`ifndef NO_ASSERTIONS
  // A job is only taken while one is queued and the back end is idle.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid && back_idle) else $error("pop from empty queue");
  // A hit never carries a miss or full status.
  a_done_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.hit |-> rsp_o.status != ST_FULL && rsp_o.status != ST_MISS)
    else $error("hit with miss status");
  // Data appears only on a found result.
  a_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.data_out != '0 |-> rsp_o.hit && rsp_o.status == ST_FOUND)
    else $error("data on non hit");
`endif
endmodule
`default_nettype wire
